/* rtl/assert_macros.svh */
// Assertion macros shared by the aligner RTL.
// Include by bare file name; needs no other file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, disabled while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// clocked check that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

/* rtl/dsta_pkg.sv */
// Types, codes and constants of the dual stream timestamp aligner.
// No dependencies; imported by the interfaces and all modules.
`default_nettype none

package dsta_pkg;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_CONTEXT = 2'd1,
    ACT_PAIR    = 2'd2,
    ACT_HALT    = 2'd3
  } action_t;

  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_CONTEXT = 1'b1;

  localparam logic REG_TOLERANCE   = 1'b0;
  localparam logic REG_HALF_PERIOD = 1'b1;

  localparam int TOL_W  = 40;
  localparam int HALF_W = 39;
  localparam int SEC_W  = 32;
  localparam int FRAC_W = 40;
  localparam int SKEW_W = 41;
  localparam int SUM_W  = 43;

  localparam logic signed [SUM_W-1:0] PS_1S = 43'sd1000000000000;
  localparam logic signed [SUM_W-1:0] PS_2S = 43'sd2000000000000;
  localparam logic signed [SUM_W-1:0] PS_3S = 43'sd3000000000000;

  typedef struct packed {
    logic [TOL_W-1:0]  skew_tol;
    logic [HALF_W-1:0] half_period_ps;
  } cfg_t;

  function automatic logic signed [SUM_W-1:0] sec_to_ps(input logic signed [2:0] ds);
    logic signed [SUM_W-1:0] v;
    case (ds)
      3'sd1:   v = PS_1S;
      3'sd2:   v = PS_2S;
      3'sd3:   v = PS_3S;
      -3'sd1:  v = -PS_1S;
      -3'sd2:  v = -PS_2S;
      -3'sd3:  v = -PS_3S;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* rtl/dsta_if.sv */
// Valid/ready channel interfaces for packet events and aligner results.
// Depends on dsta_pkg.
`default_nettype none

interface dsta_in_if import dsta_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic              source_stream;
  logic [SEC_W-1:0]  whole_seconds;
  logic [FRAC_W-1:0] fraction_ps;
  logic              lost_marker;

  modport source (output valid, kind, source_stream, whole_seconds, fraction_ps,
                  lost_marker, input ready);
  modport sink (input valid, kind, source_stream, whole_seconds, fraction_ps,
                lost_marker, output ready);
endinterface

interface dsta_out_if import dsta_pkg::*; ();
  logic                     valid;
  logic                     ready;
  action_t                  action;
  logic                     context_stream;
  logic [3:0]               pair_sequence;
  logic signed [SKEW_W-1:0] skew_value;
  logic                     drift_warning;
  logic                     want_first;
  logic                     want_second;

  modport source (output valid, action, context_stream, pair_sequence, skew_value,
                  drift_warning, want_first, want_second, input ready);
  modport sink (input valid, action, context_stream, pair_sequence, skew_value,
                drift_warning, want_first, want_second, output ready);
endinterface

`default_nettype wire

/* rtl/dsta_cfg.sv */
// APB-style register file: tolerance and half sample period.
// Depends on dsta_pkg.
`default_nettype none

module dsta_cfg import dsta_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  output logic      [63:0] cfg_prdata,
  output logic             cfg_pready,
  output cfg_t             cfg
);

  logic [TOL_W-1:0]  tol_r;
  logic [HALF_W-1:0] half_r;
  logic              wr_en;
  logic              reg_sel;

  assign cfg_pready = 1'b1;
  assign reg_sel    = cfg_paddr[3];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r  <= '0;
      half_r <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_TOLERANCE:   tol_r  <= cfg_pwdata[TOL_W-1:0];
        REG_HALF_PERIOD: half_r <= cfg_pwdata[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_TOLERANCE:   cfg_prdata = {{(64-TOL_W){1'b0}}, tol_r};
      REG_HALF_PERIOD: cfg_prdata = {{(64-HALF_W){1'b0}}, half_r};
      default:         cfg_prdata = '0;
    endcase
  end

  assign cfg.skew_tol       = tol_r;
  assign cfg.half_period_ps = half_r;

endmodule

`default_nettype wire

/* rtl/dsta_core.sv */
// Input register, timestamp state, skew and pairing logic, result register.
// Depends on dsta_pkg, dsta_if and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dsta_core import dsta_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cfg_t cfg,
  dsta_in_if.sink   in_ch,
  dsta_out_if.source out_ch
);

  // input stage
  logic              in_valid_r;
  logic              in_kind_r;
  logic              in_src_r;
  logic [SEC_W-1:0]  in_secs_r;
  logic [FRAC_W-1:0] in_frac_r;
  logic              in_lost_r;
  logic              advance;

  // block state
  logic [SEC_W-1:0]         first_seconds_r;
  logic [FRAC_W-1:0]        first_fraction_r;
  logic [SEC_W-1:0]         second_seconds_r;
  logic [FRAC_W-1:0]        second_fraction_r;
  logic                     pair_sent_r;
  logic signed [SKEW_W-1:0] locked_skew_r;
  logic                     skew_is_locked_r;
  logic [3:0]               pair_counter_r;
  logic                     stopped_r;

  // result stage
  logic                     out_valid_r;
  action_t                  action_r;
  logic                     ctx_r;
  logic [3:0]               seq_r;
  logic signed [SKEW_W-1:0] skew_r;
  logic                     drift_r;
  logic                     want1_r;
  logic                     want2_r;

  // datapath
  logic                     is_data;
  logic                     lost_hit;
  logic                     store;
  logic [SEC_W-1:0]         f_secs;
  logic [FRAC_W-1:0]        f_frac;
  logic [SEC_W-1:0]         s_secs;
  logic [FRAC_W-1:0]        s_frac;
  logic signed [SEC_W:0]    ds_wide;
  logic signed [2:0]        ds_clamp;
  logic signed [SUM_W-1:0]  frac_diff;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SKEW_W-1:0] skew;
  logic [SKEW_W-1:0]        skew_abs;
  logic                     aligned;
  logic                     have1;
  logic                     have2;
  logic                     pair_go;
  logic signed [SKEW_W:0]   lock_diff;
  logic [SKEW_W:0]          lock_abs;
  logic                     drift_hit;
  logic                     drift;

  action_t                  action_nxt;
  logic                     ctx_nxt;
  logic [3:0]               seq_nxt;
  logic signed [SKEW_W-1:0] skew_nxt;
  logic                     drift_nxt;
  logic                     want1_nxt;
  logic                     want2_nxt;

  // check terms
  logic                     halt_out;
  logic                     out_zero;
  logic                     pair_step;
  logic                     drift_step;
  logic [3:0]               cnt_plus1;
  logic                     out_stall;

  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_kind_r <= in_ch.kind;
      in_src_r  <= in_ch.source_stream;
      in_secs_r <= in_ch.whole_seconds;
      in_frac_r <= in_ch.fraction_ps;
      in_lost_r <= in_ch.lost_marker;
    end
  end

  assign is_data  = (in_kind_r == KIND_DATA);
  assign lost_hit = is_data && in_lost_r;
  assign store    = !stopped_r && is_data && !in_lost_r;

  assign f_secs = (store && !in_src_r) ? in_secs_r : first_seconds_r;
  assign f_frac = (store && !in_src_r) ? in_frac_r : first_fraction_r;
  assign s_secs = (store && in_src_r)  ? in_secs_r : second_seconds_r;
  assign s_frac = (store && in_src_r)  ? in_frac_r : second_fraction_r;

  assign ds_wide   = $signed({1'b0, f_secs}) - $signed({1'b0, s_secs});
  assign frac_diff = $signed({3'b000, f_frac}) - $signed({3'b000, s_frac});

  always_comb begin
    if (ds_wide > 33'sd3) begin
      ds_clamp = 3'sd3;
    end else if (ds_wide < -33'sd3) begin
      ds_clamp = -3'sd3;
    end else begin
      ds_clamp = ds_wide[2:0];
    end
  end

  assign sum = sec_to_ps(ds_clamp) + frac_diff;

  always_comb begin
    if (sum > PS_1S) begin
      skew = PS_1S[SKEW_W-1:0];
    end else if (sum < -PS_1S) begin
      skew = SKEW_W'(-PS_1S);
    end else begin
      skew = sum[SKEW_W-1:0];
    end
  end

  assign skew_abs = skew[SKEW_W-1] ? SKEW_W'(-skew) : skew;
  assign aligned  = (skew_abs[TOL_W-1:0] <= cfg.skew_tol);
  assign have1    = (|f_secs) || (|f_frac);
  assign have2    = (|s_secs) || (|s_frac);
  assign pair_go  = store && aligned && have1 && have2;

  assign lock_diff = {skew[SKEW_W-1], skew} - {locked_skew_r[SKEW_W-1], locked_skew_r};
  assign lock_abs  = lock_diff[SKEW_W] ? (SKEW_W+1)'(-lock_diff) : lock_diff;
  assign drift_hit = (|cfg.half_period_ps) &&
                     (lock_abs > {{(SKEW_W+1-HALF_W){1'b0}}, cfg.half_period_ps});
  assign drift     = pair_go && skew_is_locked_r && drift_hit;

  always_comb begin
    if (stopped_r || lost_hit) begin
      action_nxt = ACT_HALT;
      ctx_nxt    = 1'b0;
      seq_nxt    = '0;
      skew_nxt   = '0;
      drift_nxt  = 1'b0;
      want1_nxt  = 1'b0;
      want2_nxt  = 1'b0;
    end else begin
      if (!is_data) begin
        action_nxt = ACT_CONTEXT;
      end else if (pair_go) begin
        action_nxt = ACT_PAIR;
      end else begin
        action_nxt = ACT_NONE;
      end
      ctx_nxt   = !is_data && in_src_r;
      seq_nxt   = pair_go ? pair_counter_r : 4'd0;
      skew_nxt  = skew;
      drift_nxt = drift;
      want1_nxt = aligned || skew[SKEW_W-1] || !have1;
      want2_nxt = aligned || (!skew[SKEW_W-1] && (|skew)) || !have2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_seconds_r   <= '0;
      first_fraction_r  <= '0;
      second_seconds_r  <= '0;
      second_fraction_r <= '0;
      pair_sent_r       <= 1'b0;
      locked_skew_r     <= '0;
      skew_is_locked_r  <= 1'b0;
      pair_counter_r    <= '0;
      stopped_r         <= 1'b0;
    end else if (advance && !stopped_r) begin
      if (lost_hit) begin
        stopped_r <= 1'b1;
      end else if (is_data) begin
        first_seconds_r   <= f_secs;
        first_fraction_r  <= f_frac;
        second_seconds_r  <= s_secs;
        second_fraction_r <= s_frac;
        pair_sent_r       <= pair_go;
        if (pair_go) begin
          pair_counter_r <= pair_counter_r + 4'd1;
          if (!skew_is_locked_r) begin
            locked_skew_r    <= skew;
            skew_is_locked_r <= 1'b1;
          end else if (drift_hit) begin
            locked_skew_r <= skew;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= advance || (out_valid_r && !out_ch.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      action_r <= action_nxt;
      ctx_r    <= ctx_nxt;
      seq_r    <= seq_nxt;
      skew_r   <= skew_nxt;
      drift_r  <= drift_nxt;
      want1_r  <= want1_nxt;
      want2_r  <= want2_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.action         = action_r;
  assign out_ch.context_stream = ctx_r;
  assign out_ch.pair_sequence  = seq_r;
  assign out_ch.skew_value     = skew_r;
  assign out_ch.drift_warning  = drift_r;
  assign out_ch.want_first     = want1_r;
  assign out_ch.want_second    = want2_r;

  assign halt_out   = out_valid_r && (action_r == ACT_HALT);
  assign out_zero   = (skew_r == '0) && (seq_r == 4'd0) && !want1_r && !want2_r;
  assign pair_step  = advance && (action_nxt == ACT_PAIR);
  assign drift_step = advance && drift_nxt;
  assign cnt_plus1  = pair_counter_r + 4'd1;
  assign out_stall  = out_valid_r && !out_ch.ready;

  `ASSERT_CLK(a_halt_sticky, clk, rst_n, stopped_r |=> stopped_r)
  `ASSERT_CLK(a_halt_quiet, clk, rst_n, halt_out |-> out_zero)
  `ASSERT_CLK(a_pair_sent, clk, rst_n, pair_step |=> pair_sent_r)
  `ASSERT_CLK(a_pair_count, clk, rst_n, pair_step |=> (pair_counter_r == $past(cnt_plus1)))
  `ASSERT_CLK(a_drift_on_pair, clk, rst_n, drift_step |-> (pair_step && skew_is_locked_r))
  `ASSERT_ALWAYS(a_no_drop, clk, (rst_n && out_stall) |=> (!rst_n || out_valid_r))

endmodule

`default_nettype wire

/* rtl/dual_stream_timestamp_aligner.sv */
// Dual stream timestamp aligner: pairs timestamped data packets of two streams.
// Top level; depends on dsta_pkg, dsta_if, dsta_cfg and dsta_core.
//
// in_ch carries one parsed packet event per transfer (kind, source_stream,
// whole_seconds, fraction_ps, lost_marker); out_ch carries exactly one result
// per event: action, context_stream, pair_sequence, skew_value, drift_warning
// and the want_first / want_second read hints. A transfer happens on a rising
// edge with valid and ready both high.
// An accepted event waits in the input register until the output register is
// free or being read, then is processed into the output register, where
// out_ch.valid rises. Throughput is one event per cycle while out_ch.ready
// stays high. That rate is set by the loop that stores a timestamp, derives
// the saturated skew and updates the pair and lock state.
// When the receiver stalls, the result holds in the output register and one
// more event is still taken into the input register; in_ch.ready then drops.
// The cfg_ APB port writes the skew tolerance at address 0 and half_period_ps
// at address 8, 64-bit data, pready always high; write only while idle.
// Synchronous active-low reset clears both registers, all timestamps, the
// lock, the pair counter and the halt flag. A lost frame halts the block
// until reset; every later event then returns action halted.
`default_nettype none

module dual_stream_timestamp_aligner import dsta_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  dsta_in_if.sink          in_ch,
  dsta_out_if.source       out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  output logic      [63:0] cfg_prdata,
  output logic             cfg_pready
);

  cfg_t cfg;

  dsta_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  dsta_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

/* verif/dsta_align_checker.sv */
// Scoreboard for the dual stream timestamp aligner: watches both channels and the cfg_ port.
// Predicts each event's result from its own copy of the aligner state and compares it.
// Depends on dsta_pkg and dsta_if.
`default_nettype none

module dsta_align_checker import dsta_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  dsta_in_if               in_ch,
  dsta_out_if              out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  input  wire logic        cfg_pready,
  output int               errors,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint PS_SEC = 64'sd1000000000000;

  typedef struct packed {
    action_t                  action;
    logic                     ctx;
    logic [3:0]               seq;
    logic signed [SKEW_W-1:0] skew;
    logic                     drift;
    logic                     want0;
    logic                     want1;
  } verdict_t;

  logic [TOL_W-1:0]  tol;
  logic [HALF_W-1:0] half;
  logic [SEC_W-1:0]  ts_sec [2];
  logic [FRAC_W-1:0] ts_frac [2];
  bit                pair_done;
  bit                locked;
  bit                halted;
  longint            lock_skew;
  logic [3:0]        pair_cnt;
  verdict_t          verdict_q[$];

  function automatic verdict_t align_event(input logic kind, input logic src,
                                           input logic [SEC_W-1:0] sec,
                                           input logic [FRAC_W-1:0] frac,
                                           input logic lost);
    verdict_t r;
    longint   ds;
    longint   sk;
    longint   mag;
    longint   dev;
    bit       aligned;
    bit       have0;
    bit       have1;
    r = '0;
    r.action = ACT_NONE;
    if (halted || (kind == KIND_DATA && lost)) begin
      halted = 1'b1;
      r.action = ACT_HALT;
      return r;
    end
    if (kind == KIND_CONTEXT) begin
      r.action = ACT_CONTEXT;
      r.ctx = src;
    end else begin
      ts_sec[src] = sec;
      ts_frac[src] = frac;
      pair_done = 1'b0;
    end
    ds = $signed({32'd0, ts_sec[0]}) - $signed({32'd0, ts_sec[1]});
    if (ds > 3) ds = 3;
    if (ds < -3) ds = -3;
    sk = ds * PS_SEC + $signed({24'd0, ts_frac[0]}) - $signed({24'd0, ts_frac[1]});
    if (sk > PS_SEC) sk = PS_SEC;
    if (sk < -PS_SEC) sk = -PS_SEC;
    mag = (sk < 0) ? -sk : sk;
    aligned = mag <= $signed({24'd0, tol});
    have0 = (ts_sec[0] != '0) || (ts_frac[0] != '0);
    have1 = (ts_sec[1] != '0) || (ts_frac[1] != '0);
    if (kind == KIND_DATA && !pair_done && aligned && have0 && have1) begin
      pair_done = 1'b1;
      if (!locked) begin
        lock_skew = sk;
        locked = 1'b1;
      end else if (half != '0) begin
        dev = sk - lock_skew;
        if (dev < 0) dev = -dev;
        if (dev > $signed({25'd0, half})) begin
          r.drift = 1'b1;
          lock_skew = sk;
        end
      end
      r.action = ACT_PAIR;
      r.seq = pair_cnt;
      pair_cnt = pair_cnt + 4'd1;
    end
    r.skew = sk[SKEW_W-1:0];
    r.want0 = aligned || sk < 0 || !have0;
    r.want1 = aligned || sk > 0 || !have1;
    return r;
  endfunction

  always @(posedge clk) begin
    verdict_t exp_v;
    verdict_t got_v;
    if (!rst_n) begin
      tol = '0;
      half = '0;
      ts_sec = '{default: '0};
      ts_frac = '{default: '0};
      pair_done = 1'b0;
      locked = 1'b0;
      halted = 1'b0;
      lock_skew = 0;
      pair_cnt = '0;
      verdict_q.delete();
      pending <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[3] == REG_HALF_PERIOD) half = cfg_pwdata[HALF_W-1:0];
        else tol = cfg_pwdata[TOL_W-1:0];
      end
      if (out_ch.valid && out_ch.ready) begin
        got_v.action = out_ch.action;
        got_v.ctx = out_ch.context_stream;
        got_v.seq = out_ch.pair_sequence;
        got_v.skew = out_ch.skew_value;
        got_v.drift = out_ch.drift_warning;
        got_v.want0 = out_ch.want_first;
        got_v.want1 = out_ch.want_second;
        if (verdict_q.size() == 0) begin
          errors++;
          if (errors <= 200)
            $display("%0t: result transfer with nothing expected: act=%0d skew=%0d",
                     $realtime, got_v.action, got_v.skew);
        end else begin
          exp_v = verdict_q.pop_front();
          if (got_v !== exp_v) begin
            errors++;
            if (errors <= 200)
              $display({"%0t: mismatch expected act=%0d ctx=%0d seq=%0d skew=%0d drift=%0d ",
                        "want=%b%b, actual act=%0d ctx=%0d seq=%0d skew=%0d drift=%0d want=%b%b"},
                       $realtime, exp_v.action, exp_v.ctx, exp_v.seq, exp_v.skew, exp_v.drift,
                       exp_v.want0, exp_v.want1, got_v.action, got_v.ctx, got_v.seq,
                       got_v.skew, got_v.drift, got_v.want0, got_v.want1);
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        verdict_q.push_back(align_event(in_ch.kind, in_ch.source_stream, in_ch.whole_seconds,
                                        in_ch.fraction_ps, in_ch.lost_marker));
      pending <= verdict_q.size();
    end
  end

endmodule

`default_nettype wire

/* verif/tb.sv */
// Testbench top for the dual stream timestamp aligner: clock, reset, event stimulus and verdict.
// Drives in_ch, out_ch.ready and the cfg_ port; dsta_align_checker does all checking.
// Depends on dsta_pkg, dsta_if, the aligner RTL and dsta_align_checker.
`default_nettype none

module tb;
  import dsta_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [63:0] cfg_pwdata;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;
  int          errors;
  int          pending;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  logic        long_stall_due = 1'b0;
  longint      base_frac;
  logic [SEC_W-1:0] base_sec;

  logic [63:0] tol_set [6] = '{64'd1000, 64'd0, 64'd1000000, 64'd999999999999,
                               64'hFF_FFFF_FFFF, 64'd500000000};
  logic [63:0] half_set [6] = '{64'd500, 64'd0, 64'd1, 64'd500000000000,
                                64'd250000, 64'd1000};

  dsta_in_if  in_ch ();
  dsta_out_if out_ch ();

  dual_stream_timestamp_aligner u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  dsta_align_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .errors      (errors),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("FAILURE");
    $finish;
  end

  task automatic send_event(input logic kind, input logic src, input logic [SEC_W-1:0] sec,
                            input logic [FRAC_W-1:0] frac, input logic lost);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.source_stream <= src;
    in_ch.whole_seconds <= sec;
    in_ch.fraction_ps <= frac;
    in_ch.lost_marker <= lost;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic apb_write(input logic idx, input logic [63:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 3'b000};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // receiver: random ready, with one long hold-off on request
  initial begin
    int stall_left;
    bit stall_taken;
    stall_left = 0;
    stall_taken = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_stall_due && !stall_taken) begin
        stall_taken = 1'b1;
        stall_left = 100;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    int unsigned pick;
    int unsigned scale;
    longint      f;
    logic        src;
    logic [SEC_W-1:0] sec;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_DATA;
    in_ch.source_stream = 1'b0;
    in_ch.whole_seconds = '0;
    in_ch.fraction_ps = '0;
    in_ch.lost_marker = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    apb_write(REG_TOLERANCE, 64'd1000);
    apb_write(REG_HALF_PERIOD, 64'd500);
    tx_idle_pct = 37;
    rx_idle_pct <= 78;
    send_event(KIND_CONTEXT, 1'b0, '1, '1, 1'b1);
    send_event(KIND_CONTEXT, 1'b1, '0, '0, 1'b0);
    send_event(KIND_DATA, 1'b0, '0, '0, 1'b0);
    send_event(KIND_DATA, 1'b1, 32'd5, 40'd100, 1'b0);
    send_event(KIND_DATA, 1'b0, 32'd5, 40'd100, 1'b0);
    send_event(KIND_DATA, 1'b0, 32'd5, 40'd700, 1'b0);
    send_event(KIND_CONTEXT, 1'b0, '0, '0, 1'b0);
    send_event(KIND_DATA, 1'b1, 32'd5, 40'd700, 1'b0);
    send_event(KIND_DATA, 1'b1, 32'd5, 40'd2000, 1'b0);
    send_event(KIND_DATA, 1'b0, '1, '1, 1'b0);
    send_event(KIND_DATA, 1'b1, '0, '0, 1'b0);
    send_event(KIND_DATA, 1'b1, '1, '0, 1'b0);
    send_event(KIND_DATA, 1'b0, '0, 40'd1, 1'b0);
    send_event(KIND_DATA, 1'b0, 32'd1, '0, 1'b0);
    send_event(KIND_DATA, 1'b1, '0, 40'd999999999999, 1'b0);
    send_event(KIND_DATA, 1'b0, 32'd4, '0, 1'b0);
    send_event(KIND_DATA, 1'b1, 32'd1, '0, 1'b0);
    send_event(KIND_DATA, 1'b1, 32'd4, 40'd999, 1'b0);
    send_event(KIND_DATA, 1'b0, 32'd4, 40'd999, 1'b0);
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      apb_write(REG_TOLERANCE, tol_set[p]);
      apb_write(REG_HALF_PERIOD, half_set[p]);
      case (p % 3)
        0: begin
          tx_idle_pct = 37;
          rx_idle_pct <= 78;
        end
        1: begin
          tx_idle_pct = 78;
          rx_idle_pct <= 37;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct <= 0;
        end
      endcase
      base_sec = (p == 3) ? '1 : $urandom;
      base_frac = 64'd2000000000 + ({$urandom, $urandom} % 64'd996000000000);
      for (int n = 0; n < 150; n++) begin
        if (p == 2 && n == 20) long_stall_due <= 1'b1;
        pick = $urandom_range(99);
        src = 1'($urandom_range(1));
        if (pick < 15) begin
          send_event(KIND_CONTEXT, src, $urandom, 40'({$urandom, $urandom}),
                     1'($urandom_range(1)));
        end else if (pick < 20) begin
          send_event(KIND_DATA, src, $urandom, 40'({$urandom, $urandom}), 1'b0);
        end else if (pick < 23) begin
          send_event(KIND_DATA, src, '0, '0, 1'b0);
        end else begin
          pick = $urandom_range(99);
          scale = (pick < 25) ? 0 : (pick < 55) ? 1000 : (pick < 80) ? 1000000 : 1000000000;
          f = base_frac + longint'($urandom_range(2 * scale)) - longint'(scale);
          sec = base_sec;
          if ($urandom_range(19) == 0) sec = base_sec + $urandom_range(8) - 4;
          if ($urandom_range(49) == 0)
            base_frac = 64'd2000000000 + ({$urandom, $urandom} % 64'd996000000000);
          send_event(KIND_DATA, src, sec, f[FRAC_W-1:0], 1'b0);
        end
      end
      wait_drained();
    end

    // lost frame halts the block for the rest of the run
    tx_idle_pct = 37;
    rx_idle_pct <= 78;
    send_event(KIND_DATA, 1'b0, 32'd7, 40'd5, 1'b1);
    send_event(KIND_DATA, 1'b1, 32'd7, 40'd5, 1'b0);
    send_event(KIND_CONTEXT, 1'b1, '0, '0, 1'b0);
    send_event(KIND_DATA, 1'b0, '0, '0, 1'b1);
    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
